>>> rtl/tkbt_pkg.sv
// Shared constants, codes and default parameter values for the touch key baseline tracker.
package tkbt_pkg;

  localparam int unsigned NumKeysDefault    = 7;
  localparam int unsigned CalDepthDefault   = 24;
  localparam int unsigned StuckTicksDefault = 50;

  localparam int unsigned KeyW     = 3;
  localparam int unsigned AdcW     = 10;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [AdcW-1:0] AdcMax      = 10'd1023;
  localparam logic [AdcW-1:0] MarginReset = 10'd4;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_CAL  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MARGIN      = 1'b0,
    CFG_TOUCH_BELOW = 1'b1
  } cfg_reg_e;

endpackage

>>> rtl/touch_key_baseline_tracker.sv
// Touch key baseline tracker: per-key threshold, drift tracking, stuck and lock logic, calibration.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, operation_i, key_i,      | request in
//          | reading_i, baseline_tick_i                       |
//  out     | out_valid_o, out_stall_i, is_touched_o, ...      | request out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i| write in
//
// One request per cycle while the result is not stalled; path: input register, result register.
// All per-key and calibration state updates in the single cycle a request moves from the
// input register to the result register, so the next request sees the updated state.
// Reset clears all key state, calibration accumulators and the last-sounded key.
// A stalled result holds the input register; in_stall_o rises only when both are full.
module touch_key_baseline_tracker
  import tkbt_pkg::*;
#(
  parameter int unsigned NUM_KEYS    = NumKeysDefault,
  parameter int unsigned CAL_DEPTH   = CalDepthDefault,
  parameter int unsigned STUCK_TICKS = StuckTicksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [AdcW-1:0]     reading_i,
  input  logic                baseline_tick_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_touched_o,
  output logic                note_event_o,
  output logic                locked_event_o,
  output logic                stuck_event_o,
  output logic [AdcW-1:0]     key_baseline_o,
  output logic [AdcW-1:0]     key_threshold_o,
  output logic                cal_done_o,
  output logic [AdcW-1:0]     noise_level_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned ExtW   = IdxW + KeyW;
  localparam int unsigned TickW  = $clog2(STUCK_TICKS + 2);
  localparam int unsigned SumW   = $clog2(CAL_DEPTH * 1023 + 1);
  localparam int unsigned CntW   = $clog2(CAL_DEPTH + 1);
  localparam int unsigned DivK   = SumW + $clog2(CAL_DEPTH);
  localparam int unsigned RecipW = DivK + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << DivK) + 64'(CAL_DEPTH) - 64'd1) / 64'(CAL_DEPTH));

  function automatic logic [AdcW-1:0] thr_of(input logic [AdcW-1:0] base,
                                             input logic [AdcW-1:0] mrg,
                                             input logic            below);
    logic [AdcW:0] sum;
    logic [AdcW-1:0] res;
    if (below) begin
      sum = {1'b0, base} - {1'b0, mrg};
      res = (base < mrg) ? '0 : sum[AdcW-1:0];
    end else begin
      sum = {1'b0, base} + {1'b0, mrg};
      res = sum[AdcW] ? AdcMax : sum[AdcW-1:0];
    end
    return res;
  endfunction

  function automatic logic is_hit(input logic [AdcW-1:0] rd,
                                  input logic [AdcW-1:0] thr,
                                  input logic            below);
    return below ? (rd <= thr) : (rd >= thr);
  endfunction

  // configuration
  logic [AdcW-1:0] margin_q;
  logic            below_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
      below_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MARGIN:      margin_q <= cfg_data_i;
        CFG_TOUCH_BELOW: below_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_vld_q, out_vld_q, adv, accept;

  assign adv        = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input register
  op_e             s1_op_q;
  logic [KeyW-1:0] s1_key_q;
  logic [AdcW-1:0] s1_rd_q;
  logic            s1_tick_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_e'(operation_i);
      s1_key_q  <= key_i;
      s1_rd_q   <= reading_i;
      s1_tick_q <= baseline_tick_i;
    end
  end

  // state
  logic [AdcW-1:0]  key_base_q [NUM_KEYS];
  logic [AdcW-1:0]  key_base_d [NUM_KEYS];
  logic             key_held_q [NUM_KEYS];
  logic             key_held_d [NUM_KEYS];
  logic [TickW-1:0] ticks_q    [NUM_KEYS];
  logic [TickW-1:0] ticks_d    [NUM_KEYS];
  logic [IdxW-1:0]  last_q, last_d;
  logic             last_vld_q, last_vld_d;
  logic [SumW-1:0]  cal_sum_q, cal_sum_d;
  logic [AdcW-1:0]  cal_low_q, cal_low_d;
  logic [AdcW-1:0]  cal_high_q, cal_high_d;
  logic [CntW-1:0]  cal_cnt_q, cal_cnt_d;

  // per-request datapath
  logic [ExtW-1:0]  key_ext;
  logic [IdxW-1:0]  idx;
  logic             key_ok;
  logic [AdcW-1:0]  base0, thr0, base1, thr1, base_trk, base_out;
  logic             held0, held1, hit0, touched;
  logic [TickW-1:0] tick0, tick1;
  logic signed [AdcW+1:0] diff, diff_adj, step;
  logic [AdcW+1:0]  trk_sum;
  logic             stuck, note, locked;
  logic [SumW-1:0]  sum_n;
  logic [AdcW-1:0]  low_n, high_n, mean;
  logic [CntW-1:0]  cnt_n;
  logic             done;
  logic [ProdW-1:0] prod;

  assign key_ext = {{IdxW{1'b0}}, s1_key_q};
  assign idx     = key_ext[IdxW-1:0];
  assign key_ok  = key_ext < ExtW'(NUM_KEYS);

  assign base0 = key_base_q[idx];
  assign held0 = key_held_q[idx];
  assign tick0 = ticks_q[idx];
  assign thr0  = thr_of(base0, margin_q, below_q);
  assign hit0  = is_hit(s1_rd_q, thr0, below_q);

  assign diff     = $signed({2'b00, s1_rd_q}) - $signed({2'b00, base0});
  assign diff_adj = diff[AdcW+1] ? diff + 12'sd7 : diff;
  assign step     = diff_adj >>> 3;
  assign trk_sum  = {2'b00, base0} + $unsigned(step);
  assign base_trk = trk_sum[AdcW-1:0];

  always_comb begin
    base1 = base0;
    held1 = held0;
    tick1 = tick0;
    stuck = 1'b0;
    if (s1_tick_q) begin
      priority if (!hit0) begin
        tick1 = '0;
        base1 = base_trk;
      end else if (tick0 == '0) begin
        tick1 = TickW'(1);
      end else if (tick0 > TickW'(STUCK_TICKS)) begin
        stuck = 1'b1;
        base1 = s1_rd_q;
        tick1 = '0;
        held1 = 1'b0;
      end else begin
        tick1 = tick0 + TickW'(1);
      end
    end
  end

  assign thr1    = thr_of(base1, margin_q, below_q);
  assign touched = is_hit(s1_rd_q, thr1, below_q);
  assign locked  = touched && !held1 && last_vld_q && (last_q == idx);
  assign note    = touched && !held1 && !(last_vld_q && (last_q == idx));

  // calibration accumulators and mean by reciprocal multiply
  assign sum_n  = cal_sum_q + SumW'(s1_rd_q);
  assign low_n  = (s1_rd_q < cal_low_q) ? s1_rd_q : cal_low_q;
  assign high_n = (s1_rd_q > cal_high_q) ? s1_rd_q : cal_high_q;
  assign cnt_n  = cal_cnt_q + CntW'(1);
  assign done   = cnt_n >= CntW'(CAL_DEPTH);
  assign prod   = ProdW'(sum_n) * ProdW'(Recip);
  assign mean   = prod[DivK +: AdcW];

  always_comb begin
    key_base_d = key_base_q;
    key_held_d = key_held_q;
    ticks_d    = ticks_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    cal_sum_d  = cal_sum_q;
    cal_low_d  = cal_low_q;
    cal_high_d = cal_high_q;
    cal_cnt_d  = cal_cnt_q;
    if (adv && key_ok) begin
      unique case (s1_op_q)
        OP_CAL: begin
          if (done) begin
            key_base_d[idx] = mean;
            key_held_d[idx] = 1'b0;
            ticks_d[idx]    = '0;
            if (idx == IdxW'(NUM_KEYS - 1)) begin
              last_vld_d = 1'b0;
            end
            cal_sum_d  = '0;
            cal_low_d  = AdcMax;
            cal_high_d = '0;
            cal_cnt_d  = '0;
          end else begin
            cal_sum_d  = sum_n;
            cal_low_d  = low_n;
            cal_high_d = high_n;
            cal_cnt_d  = cnt_n;
          end
        end
        OP_SCAN: begin
          key_base_d[idx] = base1;
          key_held_d[idx] = touched;
          ticks_d[idx]    = tick1;
          if (note) begin
            last_d     = idx;
            last_vld_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_base_q[i] <= '0;
        key_held_q[i] <= 1'b0;
        ticks_q[i]    <= '0;
      end
      last_q     <= '0;
      last_vld_q <= 1'b0;
      cal_sum_q  <= '0;
      cal_low_q  <= AdcMax;
      cal_high_q <= '0;
      cal_cnt_q  <= '0;
    end else begin
      key_base_q <= key_base_d;
      key_held_q <= key_held_d;
      ticks_q    <= ticks_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
      cal_sum_q  <= cal_sum_d;
      cal_low_q  <= cal_low_d;
      cal_high_q <= cal_high_d;
      cal_cnt_q  <= cal_cnt_d;
    end
  end

  // result register
  logic            touched_q, note_q, locked_q, stuck_q, done_q;
  logic [AdcW-1:0] base_q, thr_q, noise_q;

  assign base_out = (s1_op_q == OP_CAL) ? (done ? mean : base0) : base1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      touched_q <= 1'b0;
      note_q    <= 1'b0;
      locked_q  <= 1'b0;
      stuck_q   <= 1'b0;
      done_q    <= 1'b0;
      noise_q   <= '0;
      base_q    <= '0;
      thr_q     <= '0;
      if (key_ok) begin
        base_q <= base_out;
        thr_q  <= thr_of(base_out, margin_q, below_q);
        if (s1_op_q == OP_CAL) begin
          done_q  <= done;
          noise_q <= done ? (high_n - low_n) : '0;
        end else begin
          touched_q <= touched;
          note_q    <= note;
          locked_q  <= locked;
          stuck_q   <= stuck;
        end
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign is_touched_o    = touched_q;
  assign note_event_o    = note_q;
  assign locked_event_o  = locked_q;
  assign stuck_event_o   = stuck_q;
  assign key_baseline_o  = base_q;
  assign key_threshold_o = thr_q;
  assign cal_done_o      = done_q;
  assign noise_level_o   = noise_q;

endmodule
